// ===== rtl/pol_pkg.sv =====
// Shared types and constants for the positional ordered list.
package pol_pkg;

  localparam int unsigned CapacityDef = 32;
  localparam int unsigned ValW        = 32;
  localparam int unsigned LenW        = 7;
  localparam int unsigned OpW         = 3;
  localparam int unsigned PosW        = 6;
  localparam int unsigned StatW       = 2;

  typedef enum logic [OpW-1:0] {
    OP_INS_TAIL = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_DEL_POS  = 3'd3,
    OP_RD_FWD   = 3'd4,
    OP_RD_BWD   = 3'd5
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROT_FWD,
    CELL_ROT_BWD
  } cell_act_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  typedef struct packed {
    cell_act_e          action;
    logic [LenW-1:0]    idx;
    logic [LenW-1:0]    cnt;
    logic [ValW-1:0]    value;
    logic [ValW-1:0]    wrap;
  } cell_ctl_t;

endpackage

// ===== rtl/pol_if.sv =====
// Handshake channels for list operations and list results.
interface pol_in_if;
  logic                                valid;
  logic                                ready;
  logic [pol_pkg::OpW-1:0]             op;
  logic [pol_pkg::PosW-1:0]            position;
  logic signed [pol_pkg::ValW-1:0]     value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface pol_out_if;
  logic                                valid;
  logic                                ready;
  logic [pol_pkg::StatW-1:0]           status;
  logic signed [pol_pkg::ValW-1:0]     element;
  logic [pol_pkg::LenW-1:0]            length;
  logic                                last;

  modport source (output valid, output status, output element, output length, output last,
                  input ready);
  modport sink   (input valid, input status, input element, input length, input last,
                  output ready);
endinterface

// ===== rtl/positional_ordered_list.sv =====
// Top level of the positional ordered list: cell chain, sequencer and result register.
// Keeps an ordered list of up to CAPACITY signed 32-bit values in a chain of cells, one
// element per cell. Inserts and deletes shift the cells in place, and the status result
// is registered, so an update is accepted every cycle while the result side keeps up.
// A read of n elements rotates the chain once per emitted element and blocks new items
// until its last result is loaded. The element storage has no reset; only the element
// count and control state are cleared.
module positional_ordered_list #(
  parameter int unsigned CAPACITY = pol_pkg::CapacityDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pol_in_if.sink    in_i,
  pol_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned LenW = pol_pkg::LenW;
  localparam int unsigned ValW = pol_pkg::ValW;
  localparam logic [LenW-1:0] CapLen = LenW'(CAPACITY);

  pol_pkg::state_e   state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   rd_left_q, rd_left_d;
  logic              dir_bwd_q, dir_bwd_d;

  logic                      ovalid_q, ovalid_d;
  pol_pkg::status_e          status_q, status_d;
  logic [ValW-1:0]           element_q, element_d;
  logic [LenW-1:0]           length_q, length_d;
  logic                      last_q, last_d;
  logic                      load_out;

  pol_pkg::cell_ctl_t        ctl;
  logic [ValW-1:0]           cell_val [CAPACITY];
  logic [ValW-1:0]           tail_val;
  logic [CntW-1:0]           count_m1;
  logic [LenW-1:0]           cnt_ext;
  logic [LenW-1:0]           pos_ext;
  logic                      full;
  logic                      accept;
  logic                      out_free;

  assign out_free   = !ovalid_q || out_o.ready;
  assign in_i.ready = (state_q == pol_pkg::S_IDLE) && out_free;
  assign accept     = in_i.valid && in_i.ready;

  assign cnt_ext  = LenW'(count_q);
  assign pos_ext  = LenW'(in_i.position);
  assign full     = cnt_ext >= CapLen;
  assign count_m1 = count_q - CntW'(1);
  assign tail_val = cell_val[count_m1[IdxW-1:0]];

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_left_d  = rd_left_q;
    dir_bwd_d  = dir_bwd_q;
    load_out   = 1'b0;
    status_d   = pol_pkg::STAT_OK;
    element_d  = '0;
    last_d     = 1'b1;
    ctl.action = pol_pkg::CELL_HOLD;
    ctl.idx    = '0;
    ctl.cnt    = cnt_ext;
    ctl.value  = in_i.value;
    ctl.wrap   = dir_bwd_q ? tail_val : cell_val[0];

    unique case (state_q)
      pol_pkg::S_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          unique case (in_i.op)
            pol_pkg::OP_INS_TAIL: begin
              if (full) begin
                status_d = pol_pkg::STAT_FULL;
              end else begin
                ctl.action = pol_pkg::CELL_INSERT;
                ctl.idx    = cnt_ext;
                count_d    = count_q + CntW'(1);
              end
            end
            pol_pkg::OP_INS_HEAD: begin
              if (full) begin
                status_d = pol_pkg::STAT_FULL;
              end else begin
                ctl.action = pol_pkg::CELL_INSERT;
                count_d    = count_q + CntW'(1);
              end
            end
            pol_pkg::OP_INS_POS: begin
              if (pos_ext == '0 || pos_ext > cnt_ext + LenW'(1)) begin
                status_d = pol_pkg::STAT_BADPOS;
              end else if (full) begin
                status_d = pol_pkg::STAT_FULL;
              end else begin
                ctl.action = pol_pkg::CELL_INSERT;
                ctl.idx    = pos_ext - LenW'(1);
                count_d    = count_q + CntW'(1);
              end
            end
            pol_pkg::OP_DEL_POS: begin
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                status_d = pol_pkg::STAT_BADPOS;
              end else begin
                ctl.action = pol_pkg::CELL_DELETE;
                ctl.idx    = pos_ext - LenW'(1);
                count_d    = count_m1;
              end
            end
            pol_pkg::OP_RD_FWD, pol_pkg::OP_RD_BWD: begin
              if (count_q == '0) begin
                status_d = pol_pkg::STAT_EMPTY;
              end else begin
                load_out  = 1'b0;
                state_d   = pol_pkg::S_READ;
                rd_left_d = count_q;
                dir_bwd_d = (in_i.op == pol_pkg::OP_RD_BWD);
              end
            end
            default: status_d = pol_pkg::STAT_OK;
          endcase
        end
      end
      pol_pkg::S_READ: begin
        if (out_free) begin
          load_out   = 1'b1;
          element_d  = dir_bwd_q ? tail_val : cell_val[0];
          last_d     = (rd_left_q == CntW'(1));
          ctl.action = dir_bwd_q ? pol_pkg::CELL_ROT_BWD : pol_pkg::CELL_ROT_FWD;
          rd_left_d  = rd_left_q - CntW'(1);
          if (last_d) begin
            state_d = pol_pkg::S_IDLE;
          end
        end
      end
      default: state_d = pol_pkg::S_IDLE;
    endcase

    length_d = LenW'(count_d);
    if (load_out) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ValW-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = ctl.wrap;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    pol_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .left_i (left_v),
      .right_i(right_v),
      .value_o(cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pol_pkg::S_IDLE;
      count_q   <= '0;
      rd_left_q <= '0;
      dir_bwd_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_left_q <= rd_left_d;
      dir_bwd_q <= dir_bwd_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q  <= status_d;
      element_q <= element_d;
      length_q  <= length_d;
      last_q    <= last_d;
    end
  end

  assign out_o.valid   = ovalid_q;
  assign out_o.status  = status_q;
  assign out_o.element = element_q;
  assign out_o.length  = length_q;
  assign out_o.last    = last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LenW'(count_q) <= CapLen)
    else $error("element count above capacity");

  a_read_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pol_pkg::S_READ) |=> (count_q == $past(count_q)))
    else $error("element count changed during a read");

  a_read_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pol_pkg::S_READ) |-> (rd_left_q != '0 && rd_left_q <= count_q))
    else $error("read counter out of range");

  a_read_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pol_pkg::S_READ && out_free && rd_left_q == CntW'(1))
      |=> (state_q == pol_pkg::S_IDLE && out_o.valid && out_o.last))
    else $error("read did not end on its final item");
`endif

endmodule

// ===== rtl/pol_cell.sv =====
// One storage cell of the list chain: holds one element, shifts or rotates with neighbors.
module pol_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                        clk_i,
  input  pol_pkg::cell_ctl_t          ctl_i,
  input  logic [pol_pkg::ValW-1:0]    left_i,
  input  logic [pol_pkg::ValW-1:0]    right_i,
  output logic [pol_pkg::ValW-1:0]    value_o
);

  localparam logic [pol_pkg::LenW-1:0] Pos = pol_pkg::LenW'(Idx);

  logic [pol_pkg::ValW-1:0] val_q, val_d;
  logic [pol_pkg::LenW-1:0] cnt_m1;

  assign cnt_m1 = ctl_i.cnt - pol_pkg::LenW'(1);

  always_comb begin
    val_d = val_q;
    unique case (ctl_i.action)
      pol_pkg::CELL_HOLD: val_d = val_q;
      pol_pkg::CELL_INSERT: begin
        if (Pos > ctl_i.idx) begin
          val_d = left_i;
        end else if (Pos == ctl_i.idx) begin
          val_d = ctl_i.value;
        end
      end
      pol_pkg::CELL_DELETE: begin
        if (Pos >= ctl_i.idx && Pos < cnt_m1) begin
          val_d = right_i;
        end
      end
      pol_pkg::CELL_ROT_FWD: begin
        if (Pos < cnt_m1) begin
          val_d = right_i;
        end else if (Pos == cnt_m1) begin
          val_d = ctl_i.wrap;
        end
      end
      pol_pkg::CELL_ROT_BWD: begin
        if (Pos == '0) begin
          val_d = ctl_i.wrap;
        end else begin
          val_d = left_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for positional_ordered_list: directed table, then random list traffic.
`timescale 1ns / 1ps

module tb_top;
  import pol_pkg::*;

  localparam int unsigned Capacity   = CapacityDef;
  localparam int unsigned RandItems  = 208;
  localparam int unsigned BlockLen   = 60;
  localparam int unsigned CycleLimit = 300000;

  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  typedef struct packed {
    logic [StatW-1:0]       status;
    logic signed [ValW-1:0] element;
    logic [LenW-1:0]        length;
    logic                   last;
  } list_result_t;

  typedef struct packed {
    logic [OpW-1:0]         op;
    logic [PosW-1:0]        pos;
    logic signed [ValW-1:0] val;
    logic                   typed;
    logic [StatW-1:0]       status;
    logic [LenW-1:0]        length;
  } list_row_t;

  logic clk_i;
  logic rst_ni;

  pol_in_if  in_ch ();
  pol_out_if out_ch ();

  positional_ordered_list i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  logic signed [ValW-1:0] shadow_list[$];
  list_result_t           awaited_results[$];
  list_row_t              directed_rows[22];

  int unsigned items_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned err_cnt      = 0;
  int unsigned full_seen    = 0;
  int unsigned badpos_seen  = 0;
  int unsigned empty_seen   = 0;
  int unsigned peak_len     = 0;
  int unsigned cycle_cnt    = 0;

  wire calm = (items_taken >= 150) && (items_taken < 200);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic list_row_t row(input logic [OpW-1:0] op, input int pos,
                                    input logic signed [ValW-1:0] val, input logic typed,
                                    input logic [StatW-1:0] status, input int length);
    list_row_t r;
    r.op     = op;
    r.pos    = pos[PosW-1:0];
    r.val    = val;
    r.typed  = typed;
    r.status = status;
    r.length = length[LenW-1:0];
    return r;
  endfunction

  function automatic void queue_result(input logic [StatW-1:0] status,
                                       input logic signed [ValW-1:0] element,
                                       input logic last);
    list_result_t res;
    res.status  = status;
    res.element = element;
    res.length  = LenW'(shadow_list.size());
    res.last    = last;
    awaited_results.push_back(res);
  endfunction

  function automatic void apply_list_op(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
                                        input logic signed [ValW-1:0] val);
    logic [StatW-1:0] st;
    int n;
    st = STAT_OK;
    n  = shadow_list.size();
    case (op)
      OP_INS_TAIL: begin
        if (n >= Capacity) st = STAT_FULL;
        else shadow_list.push_back(val);
      end
      OP_INS_HEAD: begin
        if (n >= Capacity) st = STAT_FULL;
        else shadow_list.push_front(val);
      end
      OP_INS_POS: begin
        if (pos == 0 || pos > n + 1) st = STAT_BADPOS;
        else if (n >= Capacity) st = STAT_FULL;
        else shadow_list.insert(int'(pos) - 1, val);
      end
      OP_DEL_POS: begin
        if (pos == 0 || pos > n) st = STAT_BADPOS;
        else shadow_list.delete(int'(pos) - 1);
      end
      default: ;
    endcase
    if (shadow_list.size() > peak_len) peak_len = shadow_list.size();
    if (op == OP_RD_FWD || op == OP_RD_BWD) begin
      if (n == 0) queue_result(STAT_EMPTY, '0, 1'b1);
      for (int i = 0; i < n; i++)
        queue_result(STAT_OK, shadow_list[(op == OP_RD_FWD) ? i : n - 1 - i], i == n - 1);
    end else begin
      queue_result(st, '0, 1'b1);
    end
  endfunction

  task automatic offer_item(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
                            input logic signed [ValW-1:0] val);
    logic taken;
    while (!calm && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.position <= pos;
    in_ch.value    <= val;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ch.ready;
      @(posedge clk_i);
    end
    items_taken++;
    apply_list_op(op, pos, val);
  endtask

  function automatic void note_mismatch(input string field, input longint exp_v,
                                        input longint act_v);
    err_cnt++;
    $display("%0t: result %0d %s mismatch, expected %0d, actual %0d",
             $time, results_seen, field, exp_v, act_v);
  endfunction

  // Result side: random stalls, one long hold-off, a calm stretch.
  initial begin : result_sink
    int  hold_left;
    logic held;
    hold_left = 0;
    held      = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && items_taken >= 70) begin
        held      = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 21);
      end
    end
  end

  always @(negedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual status %0d element %0d",
                 $time, out_ch.status, out_ch.element);
      end else begin
        exp_r = awaited_results.pop_front();
        case (exp_r.status)
          STAT_FULL:   full_seen++;
          STAT_BADPOS: badpos_seen++;
          STAT_EMPTY:  empty_seen++;
          default: ;
        endcase
        if (out_ch.status !== exp_r.status) note_mismatch("status", exp_r.status, out_ch.status);
        if (out_ch.element !== exp_r.element)
          note_mismatch("element", exp_r.element, out_ch.element);
        if (out_ch.length !== exp_r.length) note_mismatch("length", exp_r.length, out_ch.length);
        if (out_ch.last !== exp_r.last) note_mismatch("last", exp_r.last, out_ch.last);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("positional_ordered_list regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [OpW-1:0]         op;
    logic [PosW-1:0]        pos;
    logic signed [ValW-1:0] val;
    list_result_t           typed_res;
    int                     n;
    int                     roll;
    int                     ins_top;
    logic                   grow;
    rst_ni         <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= OP_INS_TAIL;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    directed_rows = '{
      row(OP_RD_FWD,   0, 0,              1'b1, STAT_EMPTY,  0),
      row(OP_RD_BWD,   0, 0,              1'b1, STAT_EMPTY,  0),
      row(OP_DEL_POS,  1, 0,              1'b1, STAT_BADPOS, 0),
      row(OP_INS_POS,  2, 5,              1'b1, STAT_BADPOS, 0),
      row(OP_INS_POS,  0, 5,              1'b1, STAT_BADPOS, 0),
      row(OP_INS_POS,  1, 32'sh8000_0000, 1'b1, STAT_OK,     1),
      row(OP_INS_TAIL, 0, 32'sh7fff_ffff, 1'b1, STAT_OK,     2),
      row(OP_INS_HEAD, 63, -1,            1'b1, STAT_OK,     3),
      row(OP_INS_POS,  4, 0,              1'b1, STAT_OK,     4),
      row(OP_INS_POS,  6, 9,              1'b1, STAT_BADPOS, 4),
      row(OP_INS_POS,  63, 9,             1'b1, STAT_BADPOS, 4),
      row(OpSpare6,    1, 1,              1'b1, STAT_OK,     4),
      row(OpSpare7,    2, -1,             1'b1, STAT_OK,     4),
      row(OP_RD_FWD,   0, 0,              1'b0, STAT_OK,     0),
      row(OP_RD_BWD,   0, 0,              1'b0, STAT_OK,     0),
      row(OP_INS_POS,  3, 32'sh5555_aaaa, 1'b0, STAT_OK,     0),
      row(OP_RD_FWD,   0, 0,              1'b0, STAT_OK,     0),
      row(OP_DEL_POS,  6, 0,              1'b1, STAT_BADPOS, 5),
      row(OP_DEL_POS,  5, 0,              1'b1, STAT_OK,     4),
      row(OP_DEL_POS,  1, 0,              1'b1, STAT_OK,     3),
      row(OP_DEL_POS,  0, 0,              1'b1, STAT_BADPOS, 3),
      row(OP_RD_BWD,   0, 0,              1'b0, STAT_OK,     0)
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      offer_item(directed_rows[r].op, directed_rows[r].pos, directed_rows[r].val);
      if (directed_rows[r].typed) begin
        typed_res         = awaited_results.pop_back();
        typed_res.status  = directed_rows[r].status;
        typed_res.element = '0;
        typed_res.length  = directed_rows[r].length;
        typed_res.last    = 1'b1;
        awaited_results.push_back(typed_res);
      end
    end

    // Alternate growing and shrinking blocks so the list reaches both full and empty.
    for (int k = 0; k < RandItems; k++) begin
      grow    = ((k / BlockLen) % 2) == 0;
      ins_top = grow ? 90 : 28;
      n       = shadow_list.size();
      roll    = $urandom_range(99);
      val     = $urandom;
      pos     = PosW'($urandom_range(63));
      if (roll < 8) begin
        op = OpW'($urandom_range(7));
      end else if (roll < 18) begin
        op = $urandom_range(1) ? OP_RD_FWD : OP_RD_BWD;
      end else if (roll < ins_top) begin
        case ($urandom_range(2))
          0: op = OP_INS_TAIL;
          1: op = OP_INS_HEAD;
          default: begin
            op  = OP_INS_POS;
            pos = PosW'($urandom_range(n + 1, 1));
          end
        endcase
      end else begin
        op  = OP_DEL_POS;
        pos = (n == 0) ? PosW'(1) : PosW'($urandom_range(n, 1));
      end
      offer_item(op, pos, val);
    end
    in_ch.valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Ran %0d list operations, checked %0d results, longest list %0d of %0d.",
             items_taken, results_seen, peak_len, Capacity);
    $display("Saw %0d full, %0d bad-position and %0d empty-read results; %0d mismatches.",
             full_seen, badpos_seen, empty_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("positional_ordered_list regression: pass");
    end else begin
      $display("positional_ordered_list regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pol_pkg.sv
rtl/pol_if.sv
rtl/pol_cell.sv
rtl/positional_ordered_list.sv
tb/tb_top.sv
